// ----- rtl/core/pcl_pkg.sv -----
// pcl_pkg: shared types and codes for the particle conservation ledger
// no dependencies
package pcl_pkg;

    typedef enum logic [2:0] {
        REQ_BEGIN  = 3'd0,
        REQ_INJECT = 3'd1,
        REQ_MOVER  = 3'd2,
        REQ_CLOSE  = 3'd3,
        REQ_QUERY  = 3'd4
    } req_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INVALID    = 2'd1;
    localparam logic [1:0] ST_UNBALANCED = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    localparam logic [1:0] DISP_ACTIVE   = 2'd0;
    localparam logic [1:0] DISP_ESCAPED  = 2'd1;
    localparam logic [1:0] DISP_ABSORBED = 2'd2;
    localparam logic [1:0] DISP_FAILED   = 2'd3;

    localparam int IN_BITS  = 80;
    localparam int OUT_BITS = 264;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_HOLD
    } bk_state_t;

endpackage

// ----- rtl/core/pcl_front.sv -----
// pcl_front: input queue, two-entry fifo between accept and execution
// depends on pcl_pkg
module pcl_front
    import pcl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [IN_BITS-1:0]  in_data,
    output logic                q_valid,
    input  logic                q_pop,
    output logic [IN_BITS-1:0]  q_data
);
    logic [IN_BITS-1:0] mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (q_pop && q_valid)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready) else $error("queue overrun");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop of empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
endmodule

// ----- rtl/core/pcl_back.sv -----
// pcl_back: row table, key match and read-modify-write of one row
// depends on pcl_pkg
module pcl_back
    import pcl_pkg::*;
#(
    parameter int NUM_ROWS   = 16,
    parameter int COUNT_BITS = 32,
    parameter int STEP_BITS  = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  logic [IN_BITS-1:0]  q_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_BITS-1:0] out_data
);
    localparam int RB = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int CB = COUNT_BITS;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    logic [NUM_ROWS-1:0] valid_reg, closed_reg;
    logic [STEP_BITS-1:0] step_reg [NUM_ROWS];
    logic [6:0]           spec_reg [NUM_ROWS];
    logic [CB-1:0] start_reg [NUM_ROWS], end_reg [NUM_ROWS], inj_reg [NUM_ROWS];
    logic [CB-1:0] adv_reg [NUM_ROWS], esc_reg [NUM_ROWS], abs_reg [NUM_ROWS];
    logic [CB-1:0] fail_reg [NUM_ROWS], crs_reg [NUM_ROWS];

    bk_state_t state_reg, state_next;
    logic [IN_BITS-1:0] req_reg;
    logic          hit_reg, free_ok_reg;
    logic [RB-1:0] hit_idx_reg, free_idx_reg;
    logic [OUT_BITS-1:0] out_reg;

    // decoded fields of the queue head and of the held item
    logic [2:0]  rq;
    logic [31:0] stp, amt;
    logic [7:0]  spc;
    logic [1:0]  disp;
    logic        shock;
    assign rq    = q_data[2:0];
    assign stp   = q_data[34:3];
    assign spc   = q_data[42:35];

    // stage 1: parallel key match and free-row search on queue head
    logic          hit, free_ok;
    logic [RB-1:0] hit_idx, free_idx;
    always_comb
    begin
        hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0;
        for (int i = NUM_ROWS-1; i >= 0; i--)
        begin
            if (valid_reg[i] && step_reg[i] == STEP_BITS'(stp)
                && spec_reg[i] == spc[6:0] && !spc[7])
            begin
                hit = 1'b1; hit_idx = RB'(i);
            end
            if (!valid_reg[i])
            begin
                free_ok = 1'b1; free_idx = RB'(i);
            end
        end
    end

    // stage 2: row update from the held request
    logic [2:0]  r_rq;
    logic [31:0] r_amt, r_stp;
    logic [7:0]  r_spc;
    assign r_rq  = req_reg[2:0];
    assign r_stp = req_reg[34:3];
    assign r_spc = req_reg[42:35];
    assign r_amt = req_reg[74:43];
    assign disp  = req_reg[76:75];
    assign shock = req_reg[77];
    assign amt   = r_amt;

    logic          amt_ok;
    logic [RB-1:0] h;
    logic [CB:0]   lhs, s1, s2, s3;
    logic [CB-1:0] dsel;
    logic          cls;
    assign h = hit_idx_reg;
    assign amt_ok = ({{(64-32){1'b0}}, amt} <= 64'(CMAX));
    always_comb
    begin
        lhs = {1'b0, start_reg[h]} + {1'b0, inj_reg[h]};
        s1  = {1'b0, CB'(amt)} + {1'b0, esc_reg[h]};
        s2  = {1'b0, s1[CB-1:0]} + {1'b0, abs_reg[h]};
        s3  = {1'b0, s2[CB-1:0]} + {1'b0, fail_reg[h]};
        case (disp)
            DISP_ACTIVE:   dsel = adv_reg[h];
            DISP_ESCAPED:  dsel = esc_reg[h];
            DISP_ABSORBED: dsel = abs_reg[h];
            default:       dsel = fail_reg[h];
        endcase
        cls = closed_reg[h];
    end
    logic [CB:0] isum;
    assign isum = {1'b0, inj_reg[h]} + {1'b0, CB'(amt)};

    logic [1:0] st;
    logic       do_begin, do_inj, do_mov, do_close;
    always_comb
    begin
        st = ST_INVALID; do_begin = 1'b0; do_inj = 1'b0; do_mov = 1'b0; do_close = 1'b0;
        case (r_rq)
            REQ_BEGIN:
                if (!r_spc[7] && !hit_reg && amt_ok)
                begin
                    if (!free_ok_reg) st = ST_FULL;
                    else begin st = ST_OK; do_begin = 1'b1; end
                end
            REQ_INJECT:
                if (hit_reg && !cls && amt_ok && !isum[CB])
                begin
                    st = ST_OK; do_inj = 1'b1;
                end
            REQ_MOVER:
                if (hit_reg && !cls && dsel != CMAX && !(shock && crs_reg[h] == CMAX))
                begin
                    st = ST_OK; do_mov = 1'b1;
                end
            REQ_CLOSE:
                if (hit_reg && !cls && amt_ok && !lhs[CB] && !s1[CB] && !s2[CB]
                    && !s3[CB])
                begin
                    if (lhs[CB-1:0] != s3[CB-1:0] || adv_reg[h] != CB'(amt))
                        st = ST_UNBALANCED;
                    else begin st = ST_OK; do_close = 1'b1; end
                end
            REQ_QUERY:
                if (hit_reg) st = ST_OK;
            default: st = ST_INVALID;
        endcase
    end

    logic exec;
    assign exec = (state_reg == BK_EXEC);

    // result fields read from the row as it stands after the update
    logic [RB-1:0] ri;
    logic          rf;
    assign ri = do_begin ? free_idx_reg : h;
    assign rf = hit_reg || do_begin;
    function automatic logic [31:0] o32(input logic [CB-1:0] v);
        return 32'(v);
    endfunction
    logic [CB-1:0] n_inj, n_adv, n_esc, n_abs, n_fail, n_crs, n_end;
    always_comb
    begin
        n_inj  = inj_reg[ri];  n_adv = adv_reg[ri];  n_esc = esc_reg[ri];
        n_abs  = abs_reg[ri];  n_fail = fail_reg[ri]; n_crs = crs_reg[ri];
        n_end  = end_reg[ri];
        if (do_begin)
        begin
            n_inj = '0; n_adv = '0; n_esc = '0; n_abs = '0; n_fail = '0;
            n_crs = '0; n_end = '0;
        end
        if (do_inj) n_inj = isum[CB-1:0];
        if (do_mov)
        begin
            case (disp)
                DISP_ACTIVE:   n_adv  = adv_reg[h] + 1'b1;
                DISP_ESCAPED:  n_esc  = esc_reg[h] + 1'b1;
                DISP_ABSORBED: n_abs  = abs_reg[h] + 1'b1;
                default:       n_fail = fail_reg[h] + 1'b1;
            endcase
            if (shock) n_crs = crs_reg[h] + 1'b1;
        end
        if (do_close) n_end = CB'(amt);
    end
    logic [CB-1:0] n_start;
    assign n_start = do_begin ? CB'(amt) : start_reg[ri];
    logic n_cls;
    assign n_cls = do_close ? 1'b1 : (do_begin ? 1'b0 : closed_reg[ri]);

    always_ff @(posedge clk)
    begin
        if (exec && rf)
        begin
            if (do_begin)
            begin
                step_reg[ri] <= STEP_BITS'(r_stp);
                spec_reg[ri] <= r_spc[6:0];
            end
            start_reg[ri] <= n_start; end_reg[ri] <= n_end; inj_reg[ri] <= n_inj;
            adv_reg[ri] <= n_adv; esc_reg[ri] <= n_esc; abs_reg[ri] <= n_abs;
            fail_reg[ri] <= n_fail; crs_reg[ri] <= n_crs;
        end
        if (q_pop)
        begin
            req_reg      <= q_data;
            hit_reg      <= hit;
            hit_idx_reg  <= hit_idx;
            free_ok_reg  <= free_ok;
            free_idx_reg <= free_idx;
        end
        if (exec)
            out_reg <= rf ? {4'd0, o32(n_crs), o32(n_fail), o32(n_abs), o32(n_esc),
                             o32(n_adv), o32(n_inj), o32(n_end), o32(n_start),
                             n_cls, 1'b1, st}
                          : {262'd0, st};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            valid_reg  <= '0;
            closed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec && do_begin)
            begin
                valid_reg[free_idx_reg]  <= 1'b1;
                closed_reg[free_idx_reg] <= 1'b0;
            end
            if (exec && do_close)
                closed_reg[h] <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        unique case (state_reg)
            BK_IDLE:
                if (q_valid) begin q_pop = 1'b1; state_next = BK_EXEC; end
            BK_EXEC: state_next = BK_HOLD;
            BK_HOLD:
                if (out_ready)
                begin
                    if (q_valid) begin q_pop = 1'b1; state_next = BK_EXEC; end
                    else state_next = BK_IDLE;
                end
            default: state_next = BK_IDLE;
        endcase
    end

    assign out_valid = (state_reg == BK_HOLD);
    assign out_data  = out_reg;

    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_begin_free: assert property (@(posedge clk) disable iff (!rst_n)
        exec && do_begin |-> !valid_reg[free_idx_reg]) else $error("begin on used row");
    a_upd_open: assert property (@(posedge clk) disable iff (!rst_n)
        exec && (do_inj || do_mov || do_close) |-> hit_reg && !cls)
        else $error("update on closed row");
endmodule

// ----- rtl/core/particle_conservation_ledger.sv -----
// particle_conservation_ledger: top level, queue front and row-table back
// depends on pcl_pkg, pcl_front, pcl_back
//
// usage: requests arrive on the s_axis group, one item per request; each
// request returns exactly one result item on m_axis, in order.
// s_axis_tdata: req_type, step_id, species_id, amount, disposition,
// shock_crossed from the low bit up. m_axis_tdata: status, row_found,
// row_closed, then the eight 32-bit counters.
// a two-entry queue sits in front; the back end pops one item, matches
// its key against all rows in the pop cycle, then updates the row and
// registers the result in the following cycle.
// the back end takes one item at a time: it pops the next one only when
// the last result is taken, so same-row requests need no forwarding
// since each finishes before the next key match.
// reset: all rows invalid and open, queue empty, no result pending.
// receiver stall: the result is held in the output register while the
// queue keeps taking items until both entries are full.
module particle_conservation_ledger
    import pcl_pkg::*;
#(
    parameter int NUM_ROWS   = 16,
    parameter int COUNT_BITS = 32,
    parameter int STEP_BITS  = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // req_type, step_id, species_id, amount, disposition, shock_crossed
    input  logic [IN_BITS-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // status, row_found, row_closed, start, end, injected, advanced,
    // escaped, absorbed, failed, crossing
    output logic [OUT_BITS-1:0] m_axis_tdata
);
    logic               q_valid, q_pop;
    logic [IN_BITS-1:0] q_data;

    pcl_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );

    pcl_back #(
        .NUM_ROWS(NUM_ROWS), .COUNT_BITS(COUNT_BITS), .STEP_BITS(STEP_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
    );
endmodule

// ----- sim/pcl_ledger_checker.sv -----
// pcl_ledger_checker: watches both stream groups of the ledger, keeps its own copy
// of the row table, predicts each result and compares it field by field
// depends on pcl_pkg
module pcl_ledger_checker
    import pcl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [IN_BITS-1:0]  s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OUT_BITS-1:0] m_tdata,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = 16;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    logic        tbl_valid  [ROWS];
    logic        tbl_closed [ROWS];
    logic [31:0] tbl_step   [ROWS];
    logic [6:0]  tbl_spec   [ROWS];
    logic [31:0] tbl_start  [ROWS];
    logic [31:0] tbl_end    [ROWS];
    logic [31:0] tbl_inj    [ROWS];
    logic [31:0] tbl_adv    [ROWS];
    logic [31:0] tbl_esc    [ROWS];
    logic [31:0] tbl_abs    [ROWS];
    logic [31:0] tbl_fail   [ROWS];
    logic [31:0] tbl_cross  [ROWS];

    logic [OUT_BITS-1:0] ledger_results [$];
    int                  n_fail;

    assign fail_count = n_fail;
    assign pending    = ledger_results.size();

    // bump one counter unless it is saturated
    function automatic logic bump_ok(inout logic [31:0] c);
        if (c == CNT_MAX)
            return 1'b0;
        c = c + 32'd1;
        return 1'b1;
    endfunction

    function automatic logic [OUT_BITS-1:0] apply_request(input logic [IN_BITS-1:0] d);
        logic [2:0]  req;
        logic [31:0] step;
        logic [7:0]  spec;
        logic [31:0] amt;
        logic [1:0]  disp;
        logic        shock;
        logic [1:0]  st;
        int          r;
        int          fr;
        logic [32:0] lhs;
        logic [32:0] rhs;
        logic [31:0] a, e, b, f, c;
        logic        ok;
        logic [OUT_BITS-1:0] res;
        req   = d[2:0];
        step  = d[34:3];
        spec  = d[42:35];
        amt   = d[74:43];
        disp  = d[76:75];
        shock = d[77];
        st    = ST_INVALID;
        r     = -1;
        fr    = -1;
        res   = '0;
        if (!spec[7])
            for (int i = 0; i < ROWS; i++)
                if (r < 0 && tbl_valid[i] && tbl_step[i] == step && tbl_spec[i] == spec[6:0])
                    r = i;
        case (req)
            REQ_BEGIN:
            begin
                if (!spec[7] && r < 0)
                begin
                    for (int i = ROWS - 1; i >= 0; i--)
                        if (!tbl_valid[i])
                            fr = i;
                    if (fr < 0)
                        st = ST_FULL;
                    else
                    begin
                        tbl_valid[fr]  = 1'b1;
                        tbl_closed[fr] = 1'b0;
                        tbl_step[fr]   = step;
                        tbl_spec[fr]   = spec[6:0];
                        tbl_start[fr]  = amt;
                        tbl_end[fr]    = '0;
                        tbl_inj[fr]    = '0;
                        tbl_adv[fr]    = '0;
                        tbl_esc[fr]    = '0;
                        tbl_abs[fr]    = '0;
                        tbl_fail[fr]   = '0;
                        tbl_cross[fr]  = '0;
                        r  = fr;
                        st = ST_OK;
                    end
                end
            end
            REQ_INJECT:
            begin
                if (r >= 0 && !tbl_closed[r])
                begin
                    lhs = {1'b0, tbl_inj[r]} + {1'b0, amt};
                    if (!lhs[32])
                    begin
                        tbl_inj[r] = lhs[31:0];
                        st = ST_OK;
                    end
                end
            end
            REQ_MOVER:
            begin
                if (r >= 0 && !tbl_closed[r])
                begin
                    a = tbl_adv[r];
                    e = tbl_esc[r];
                    b = tbl_abs[r];
                    f = tbl_fail[r];
                    c = tbl_cross[r];
                    case (disp)
                        DISP_ACTIVE:   ok = bump_ok(a);
                        DISP_ESCAPED:  ok = bump_ok(e);
                        DISP_ABSORBED: ok = bump_ok(b);
                        default:       ok = bump_ok(f);
                    endcase
                    if (ok && shock)
                        ok = bump_ok(c);
                    // all or nothing
                    if (ok)
                    begin
                        tbl_adv[r]   = a;
                        tbl_esc[r]   = e;
                        tbl_abs[r]   = b;
                        tbl_fail[r]  = f;
                        tbl_cross[r] = c;
                        st = ST_OK;
                    end
                end
            end
            REQ_CLOSE:
            begin
                if (r >= 0 && !tbl_closed[r])
                begin
                    lhs = {1'b0, tbl_start[r]} + {1'b0, tbl_inj[r]};
                    ok  = !lhs[32];
                    rhs = {1'b0, amt} + {1'b0, tbl_esc[r]};
                    ok  = ok && !rhs[32];
                    rhs = {1'b0, rhs[31:0]} + {1'b0, tbl_abs[r]};
                    ok  = ok && !rhs[32];
                    rhs = {1'b0, rhs[31:0]} + {1'b0, tbl_fail[r]};
                    ok  = ok && !rhs[32];
                    if (ok)
                    begin
                        if (lhs[31:0] != rhs[31:0] || tbl_adv[r] != amt)
                            st = ST_UNBALANCED;
                        else
                        begin
                            tbl_end[r]    = amt;
                            tbl_closed[r] = 1'b1;
                            st = ST_OK;
                        end
                    end
                end
            end
            REQ_QUERY:
            begin
                if (r >= 0)
                    st = ST_OK;
            end
            default:
            begin
            end
        endcase
        res[1:0] = st;
        if (r >= 0)
        begin
            res[2]       = 1'b1;
            res[3]       = tbl_closed[r];
            res[35:4]    = tbl_start[r];
            res[67:36]   = tbl_end[r];
            res[99:68]   = tbl_inj[r];
            res[131:100] = tbl_adv[r];
            res[163:132] = tbl_esc[r];
            res[195:164] = tbl_abs[r];
            res[227:196] = tbl_fail[r];
            res[259:228] = tbl_cross[r];
        end
        return res;
    endfunction

    task automatic check_result(input logic [OUT_BITS-1:0] got);
        logic [OUT_BITS-1:0] want;
        string               names [11];
        int                  lo    [11];
        int                  wd    [11];
        logic [31:0]         wv;
        logic [31:0]         gv;
        names = '{"status", "row_found", "row_closed", "start_count", "end_count",
                  "injected_count", "advanced_count", "escaped_count", "absorbed_count",
                  "failed_count", "crossing_count"};
        lo    = '{0, 2, 3, 4, 36, 68, 100, 132, 164, 196, 228};
        wd    = '{2, 1, 1, 32, 32, 32, 32, 32, 32, 32, 32};
        if (ledger_results.size() == 0)
        begin
            $display("%0t ns: result with nothing expected, actual %h", $realtime, got);
            n_fail++;
            return;
        end
        want = ledger_results.pop_front();
        for (int k = 0; k < 11; k++)
        begin
            wv = 32'((want >> lo[k]) & ((64'd1 << wd[k]) - 1));
            gv = 32'((got >> lo[k]) & ((64'd1 << wd[k]) - 1));
            if (wv !== gv)
            begin
                $display("%0t ns: %s expected %h actual %h", $realtime, names[k], wv, gv);
                n_fail++;
            end
        end
        if (got[OUT_BITS-1:260] !== '0)
        begin
            $display("%0t ns: padding expected 0 actual %h", $realtime, got[OUT_BITS-1:260]);
            n_fail++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_fail = 0;
            ledger_results.delete();
            for (int i = 0; i < ROWS; i++)
            begin
                tbl_valid[i]  = 1'b0;
                tbl_closed[i] = 1'b0;
            end
        end
        else
        begin
            if (s_tvalid && s_tready)
                ledger_results.insert(ledger_results.size(), apply_request(s_tdata));
            if (m_tvalid && m_tready)
                check_result(m_tdata);
        end
    end

endmodule

// ----- sim/tb_particle_conservation_ledger.sv -----
// tb_particle_conservation_ledger: stimulus and verdict for the conservation ledger
// depends on pcl_pkg, particle_conservation_ledger and pcl_ledger_checker
module tb_particle_conservation_ledger;
    import pcl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // req_type, step_id, species_id, amount, disposition, shock_crossed
    logic [IN_BITS-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // status, row_found, row_closed, start, end, injected, advanced,
    // escaped, absorbed, failed, crossing
    logic [OUT_BITS-1:0] m_axis_tdata;

    int fail_count;
    int pending;

    // idle percentages of each side, changed per phase
    int send_idle;
    int recv_idle;

    // long receiver hold-off, requested by the sender and counted by the receiver
    int hold_reqs;
    int hold_seen;
    int hold_left;

    int cycles;
    int n_items;
    int n_runs;

    // keys already offered to begin, reused by the noise items
    logic [31:0] seen_step [$];
    logic [7:0]  seen_spec [$];

    particle_conservation_ledger i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pcl_ledger_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAIL particle_conservation_ledger");
            $finish;
        end
    end

    // receiver: random back-pressure plus the occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_seen     <= 0;
            hold_left     <= 0;
        end
        else if (hold_reqs != hold_seen)
        begin
            hold_seen     <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic [IN_BITS-1:0] pack_req(input logic [2:0] req, input logic [31:0] step,
                                                    input logic [7:0] spec, input logic [31:0] amt,
                                                    input logic [1:0] disp, input logic shock);
        return {2'b00, shock, disp, amt, spec, step, req};
    endfunction

    // offer one item, with random gaps ahead of it, and wait until taken
    task automatic send_item(input logic [IN_BITS-1:0] d);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_items++;
    endtask

    task automatic send_fields(input logic [2:0] req, input logic [31:0] step, input logic [7:0] spec,
                               input logic [31:0] amt, input logic [1:0] disp, input logic shock);
        if (req == REQ_BEGIN)
        begin
            seen_step.insert(seen_step.size(), step);
            seen_spec.insert(seen_spec.size(), spec);
        end
        send_item(pack_req(req, step, spec, amt, disp, shock));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // well-formed life of one row: begin, one inject, one mover per particle, close
    task automatic row_lifecycle;
        logic [31:0] step;
        logic [7:0]  spec;
        int          n_start;
        int          n_inj;
        int          n_act;
        logic [1:0]  disp;
        step    = $urandom();
        spec    = 8'($urandom_range(127));
        n_start = $urandom_range(6);
        n_inj   = $urandom_range(4);
        n_act   = 0;
        send_fields(REQ_BEGIN, step, spec, n_start, DISP_ACTIVE, 1'b0);
        if (n_inj > 0)
            send_fields(REQ_INJECT, step, spec, n_inj, DISP_ACTIVE, 1'b0);
        for (int k = 0; k < n_start + n_inj; k++)
        begin
            disp = 2'($urandom_range(3));
            if (disp == DISP_ACTIVE)
                n_act++;
            send_fields(REQ_MOVER, step, spec, '0, disp, 1'(($urandom_range(3) == 0)));
            if ($urandom_range(7) == 0)
                send_fields(REQ_QUERY, step, spec, $urandom(), 2'($urandom_range(3)),
                            1'($urandom()));
        end
        // sometimes a close with the wrong end count first
        if ($urandom_range(3) == 0)
            send_fields(REQ_CLOSE, step, spec, n_act + 1, DISP_ACTIVE, 1'b0);
        send_fields(REQ_CLOSE, step, spec, n_act, DISP_ACTIVE, 1'b0);
        send_fields(REQ_INJECT, step, spec, 32'd1, DISP_ACTIVE, 1'b0);
        n_runs++;
    endtask

    function automatic logic [31:0] pick_amount;
        case ($urandom_range(5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return $urandom_range(8);
        endcase
    endfunction

    // random request, mostly on known keys, any type code and any species
    task automatic noise_item;
        logic [31:0] step;
        logic [7:0]  spec;
        int          j;
        if (seen_step.size() > 0 && $urandom_range(9) < 7)
        begin
            j    = $urandom_range(seen_step.size() - 1);
            step = seen_step[j];
            spec = seen_spec[j];
        end
        else
        begin
            step = $urandom();
            spec = 8'($urandom());
        end
        send_item(pack_req(3'($urandom_range(7)), step, spec, pick_amount(),
                           2'($urandom_range(3)), 1'($urandom())));
    endtask

    task automatic random_phase(input int n);
        int start_items;
        start_items = n_items;
        while (n_items - start_items < n)
        begin
            if (n_runs < 14 && $urandom_range(15) == 0)
                row_lifecycle();
            else
                noise_item();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        send_idle     = 28;
        recv_idle     = 45;
        hold_reqs     = 0;
        n_items       = 0;
        n_runs        = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a balanced row through every operation and disposition
        send_fields(REQ_BEGIN, 32'd1, 8'sd5, 32'd3, DISP_ACTIVE, 1'b0);
        send_fields(REQ_BEGIN, 32'd1, 8'sd5, 32'd9, DISP_ACTIVE, 1'b0);          // duplicate key
        send_fields(REQ_BEGIN, 32'd1, -8'sd128, 32'd1, DISP_ACTIVE, 1'b0);       // negative species
        send_fields(REQ_INJECT, 32'd1, 8'sd5, 32'd2, DISP_ACTIVE, 1'b0);
        send_fields(REQ_MOVER, 32'd1, 8'sd5, '0, DISP_ACTIVE, 1'b1);
        send_fields(REQ_MOVER, 32'd1, 8'sd5, '0, DISP_ACTIVE, 1'b0);
        send_fields(REQ_MOVER, 32'd1, 8'sd5, '0, DISP_ESCAPED, 1'b1);
        send_fields(REQ_MOVER, 32'd1, 8'sd5, '0, DISP_ABSORBED, 1'b0);
        send_fields(REQ_MOVER, 32'd1, 8'sd5, '0, DISP_FAILED, 1'b1);
        send_fields(REQ_CLOSE, 32'd1, 8'sd5, 32'd3, DISP_ACTIVE, 1'b0);          // not conserved
        send_fields(REQ_CLOSE, 32'd1, 8'sd5, 32'd2, DISP_ACTIVE, 1'b0);
        send_fields(REQ_INJECT, 32'd1, 8'sd5, 32'd1, DISP_ACTIVE, 1'b0);         // closed row
        send_fields(REQ_QUERY, 32'd1, 8'sd5, '0, DISP_ACTIVE, 1'b0);
        send_fields(REQ_QUERY, 32'd2, 8'sd5, '0, DISP_ACTIVE, 1'b0);             // missing row
        send_fields(REQ_QUERY, 32'd1, -8'sd1, '0, DISP_ACTIVE, 1'b0);
        send_fields(3'd5, 32'd1, 8'sd5, '0, DISP_ACTIVE, 1'b0);                  // unknown codes
        send_fields(3'd7, 32'hFFFF_FFFF, 8'sd127, 32'hFFFF_FFFF, DISP_FAILED, 1'b1);
        // counter overflow on inject
        send_fields(REQ_BEGIN, 32'hFFFF_FFFF, 8'sd127, 32'hFFFF_FFFF, DISP_ACTIVE, 1'b0);
        send_fields(REQ_INJECT, 32'hFFFF_FFFF, 8'sd127, 32'd0, DISP_ACTIVE, 1'b0);
        send_fields(REQ_BEGIN, 32'd0, 8'sd0, 32'd0, DISP_ACTIVE, 1'b0);
        send_fields(REQ_INJECT, 32'd0, 8'sd0, 32'hFFFF_FFFF, DISP_ACTIVE, 1'b0);
        send_fields(REQ_INJECT, 32'd0, 8'sd0, 32'd1, DISP_ACTIVE, 1'b0);
        // close whose right-hand sum overflows
        send_fields(REQ_MOVER, 32'd0, 8'sd0, '0, DISP_ESCAPED, 1'b0);
        send_fields(REQ_CLOSE, 32'd0, 8'sd0, 32'hFFFF_FFFF, DISP_ACTIVE, 1'b0);

        // sender waits for the pipe to empty before the random part
        drain();

        random_phase(530);
        // long receiver hold-off while the sender keeps offering
        hold_reqs++;
        random_phase(40);

        send_idle = 45;
        recv_idle = 28;
        random_phase(530);
        drain();

        send_idle = 0;
        recv_idle = 0;
        random_phase(500);

        drain();
        repeat (10) @(posedge clk);
        $display("run covered %0d requests, %0d full row lifecycles, table filling and",
                 n_items, n_runs);
        $display("overflow, duplicate, closed-row and unknown-code requests under back-pressure");
        if (fail_count == 0)
            $display("PASS particle_conservation_ledger");
        else
            $display("FAIL particle_conservation_ledger");
        $finish;
    end

endmodule
